### hdl/fcu_pkg.sv
// ---------------------------------------------------------------------------
// fcu_pkg: shared types and codes of the funnel chain update block
// Point, queue item, result and orientation unit types; result and action codes.
// ---------------------------------------------------------------------------
`default_nettype none

package fcu_pkg;

   localparam int COORD_W          = 32;
   localparam int FACE_W           = 24;
   localparam int DEF_CHAIN_DEPTH  = 32;
   localparam int DEF_COORD_BITS   = 32;

   // result kinds
   localparam logic [1:0] KIND_STATUS = 2'd0;
   localparam logic [1:0] KIND_NEIGH  = 2'd1;
   localparam logic [1:0] KIND_LEFT   = 2'd2;
   localparam logic [1:0] KIND_RIGHT  = 2'd3;

   // actions
   localparam logic [2:0] ACT_SPLIT     = 3'd0;
   localparam logic [2:0] ACT_EXT_LEFT  = 3'd1;
   localparam logic [2:0] ACT_SHR_LEFT  = 3'd2;
   localparam logic [2:0] ACT_EXT_RIGHT = 3'd3;
   localparam logic [2:0] ACT_SHR_RIGHT = 3'd4;
   localparam logic [2:0] ACT_STARTED   = 3'd5;
   localparam logic [2:0] ACT_ERROR     = 3'd6;

   // orientation of o against a->b
   localparam logic [1:0] ORI_ZERO  = 2'd0;
   localparam logic [1:0] ORI_RIGHT = 2'd1;
   localparam logic [1:0] ORI_LEFT  = 2'd2;

   typedef struct packed {
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] x;
   } point_type;

   typedef struct packed {
      logic              func;
      point_type         o;
      point_type         lft;
      point_type         rgt;
      logic [FACE_W-1:0] face;
   } item_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [2:0]        action;
      point_type         pt;
      logic [FACE_W-1:0] face;
      point_type         bl;
      point_type         br;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic      start;
      point_type o;
      point_type a;
      point_type b;
   } ori_req_type;

   typedef struct packed {
      logic       done;
      logic [1:0] res;
   } ori_rsp_type;

endpackage

`default_nettype wire

### hdl/fcu_front.sv
// ---------------------------------------------------------------------------
// fcu_front: input side
// Takes request transactions, narrows coordinates and queues them (2 deep).
// ---------------------------------------------------------------------------
`default_nettype none

module fcu_front import fcu_pkg::*; #(
   parameter int COORD_BITS = DEF_COORD_BITS
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   output logic          in_ready,
   input  wire item_type in_item,
   output logic          q_valid,
   output item_type      q_item,
   input  wire logic     q_pop
);

   item_type   queue_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   item_type   narrowed;

   // keep the low COORD_BITS of each coordinate, sign extended
   function automatic logic signed [COORD_W-1:0] narrow(input logic [COORD_W-1:0] v);
      logic signed [COORD_BITS-1:0] t;
      t = v[COORD_BITS-1:0];
      return COORD_W'(t);
   endfunction

   always_comb begin
      narrowed       = in_item;
      narrowed.func  = in_item.func;
      narrowed.o.x   = narrow(in_item.o.x);
      narrowed.o.y   = narrow(in_item.o.y);
      narrowed.lft.x = narrow(in_item.lft.x);
      narrowed.lft.y = narrow(in_item.lft.y);
      narrowed.rgt.x = narrow(in_item.rgt.x);
      narrowed.rgt.y = narrow(in_item.rgt.y);
   end

   assign in_ready = (cnt_ff != 2'd2);
   assign push     = in_valid && in_ready;
   assign q_valid  = (cnt_ff != 2'd0);
   assign q_item   = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ q_pop;
      cnt_in    = cnt_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= narrowed;
      end
   end

endmodule

`default_nettype wire

### hdl/fcu_orient.sv
// ---------------------------------------------------------------------------
// fcu_orient: orientation test
// Three stage pipeline: differences, two products, compare of the products.
// ---------------------------------------------------------------------------
`default_nettype none

module fcu_orient import fcu_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire ori_req_type ori_req,
   output ori_rsp_type      ori_rsp
);

   localparam int DW = COORD_W + 1;
   localparam int PW = 2 * DW;

   logic signed [DW-1:0] dx1_ff, dy1_ff, dx2_ff, dy2_ff;
   logic signed [DW-1:0] dx1_in, dy1_in, dx2_in, dy2_in;
   logic signed [PW-1:0] p1_ff, p2_ff, p1_in, p2_in;
   logic [1:0]           res_ff, res_in;
   logic [2:0]           vld_ff, vld_in;

   always_comb begin
      dx1_in = DW'(ori_req.b.x) - DW'(ori_req.a.x);
      dy1_in = DW'(ori_req.b.y) - DW'(ori_req.a.y);
      dx2_in = DW'(ori_req.o.x) - DW'(ori_req.a.x);
      dy2_in = DW'(ori_req.o.y) - DW'(ori_req.a.y);
      p1_in  = dx1_ff * dy2_ff;
      p2_in  = dy1_ff * dx2_ff;
      priority if (p1_ff > p2_ff) begin
         res_in = ORI_LEFT;
      end else if (p1_ff < p2_ff) begin
         res_in = ORI_RIGHT;
      end else begin
         res_in = ORI_ZERO;
      end
      vld_in = {vld_ff[1:0], ori_req.start};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 3'd0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      dx1_ff <= dx1_in;
      dy1_ff <= dy1_in;
      dx2_ff <= dx2_in;
      dy2_ff <= dy2_in;
      p1_ff  <= p1_in;
      p2_ff  <= p2_in;
      res_ff <= res_in;
   end

   assign ori_rsp.done = vld_ff[2];
   assign ori_rsp.res  = res_ff;

endmodule

`default_nettype wire

### hdl/fcu_back.sv
// ---------------------------------------------------------------------------
// fcu_back: execution side
// Sequencer over the chain memories, orientation unit and result register.
// ---------------------------------------------------------------------------
`default_nettype none

module fcu_back import fcu_pkg::*; #(
   parameter int CHAIN_DEPTH = DEF_CHAIN_DEPTH
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     q_valid,
   input  wire item_type q_item,
   output logic          q_pop,
   output logic          out_valid,
   output rsp_type       out_data,
   input  wire logic     out_ready
);

   localparam int CNT_W = $clog2(CHAIN_DEPTH + 1);
   localparam int IDX_W = $clog2(CHAIN_DEPTH);

   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_START2 = 5'd1;
   localparam logic [4:0] S_ORL0   = 5'd2;
   localparam logic [4:0] S_ORL    = 5'd3;
   localparam logic [4:0] S_ORR0   = 5'd4;
   localparam logic [4:0] S_ORR    = 5'd5;
   localparam logic [4:0] S_DECIDE = 5'd6;
   localparam logic [4:0] S_WRD    = 5'd7;
   localparam logic [4:0] S_WOR    = 5'd8;
   localparam logic [4:0] S_WWAIT  = 5'd9;
   localparam logic [4:0] S_APPLY  = 5'd10;
   localparam logic [4:0] S_STATUS = 5'd11;
   localparam logic [4:0] S_SNB    = 5'd12;
   localparam logic [4:0] S_SRD    = 5'd13;
   localparam logic [4:0] S_SEM    = 5'd14;
   localparam logic [4:0] S_SAPEX  = 5'd15;
   localparam logic [4:0] S_SO     = 5'd16;
   localparam logic [4:0] S_SW0    = 5'd17;
   localparam logic [4:0] S_SW1    = 5'd18;

   point_type left_mem  [CHAIN_DEPTH];
   point_type right_mem [CHAIN_DEPTH];

   logic [4:0]        state_ff, state_in;
   logic [CNT_W-1:0]  lcnt_ff, lcnt_in, rcnt_ff, rcnt_in, i_ff, i_in;
   point_type         l0_ff, l0_in, l1_ff, l1_in, r0_ff, r0_in, r1_ff, r1_in;
   point_type         lbase_ff, lbase_in, rbase_ff, rbase_in;
   point_type         o_ff, o_in, lin_ff, lin_in, rin_ff, rin_in, prev_ff, prev_in;
   logic [FACE_W-1:0] face_ff, face_in;
   logic [1:0]        lo_ff, lo_in, ro_ff, ro_in;
   logic              side_ff, side_in, hit_ff, hit_in;
   logic [2:0]        action_ff, action_in;
   point_type         lrd_ff, rrd_ff, rd_pt;
   logic [IDX_W-1:0]  rd_addr;
   logic              rd_en;

   logic              lwe, rwe;
   logic [IDX_W-1:0]  lwa, rwa;
   point_type         lwd, rwd;

   logic              out_valid_ff;
   rsp_type           out_ff;
   logic              can_emit, emit;
   rsp_type           emit_data;

   ori_req_type       ori_req;
   ori_rsp_type       ori_rsp;
   logic [1:0]        target;

   fcu_orient u_orient (
      .clock   (clock),
      .reset   (reset),
      .ori_req (ori_req),
      .ori_rsp (ori_rsp)
   );

   assign can_emit  = !out_valid_ff || out_ready;
   assign rd_pt     = side_ff ? lrd_ff : rrd_ff;
   assign target    = side_ff ? ORI_RIGHT : ORI_LEFT;
   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

   always_comb begin
      state_in  = state_ff;
      lcnt_in   = lcnt_ff;
      rcnt_in   = rcnt_ff;
      i_in      = i_ff;
      l0_in     = l0_ff;
      l1_in     = l1_ff;
      r0_in     = r0_ff;
      r1_in     = r1_ff;
      lbase_in  = lbase_ff;
      rbase_in  = rbase_ff;
      o_in      = o_ff;
      lin_in    = lin_ff;
      rin_in    = rin_ff;
      prev_in   = prev_ff;
      face_in   = face_ff;
      lo_in     = lo_ff;
      ro_in     = ro_ff;
      side_in   = side_ff;
      hit_in    = hit_ff;
      action_in = action_ff;
      q_pop     = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = i_ff[IDX_W-1:0];
      lwe       = 1'b0;
      rwe       = 1'b0;
      lwa       = '0;
      rwa       = '0;
      lwd       = o_ff;
      rwd       = o_ff;
      emit      = 1'b0;
      ori_req.start = 1'b0;
      ori_req.o     = o_ff;
      ori_req.a     = l0_ff;
      ori_req.b     = l1_ff;

      emit_data.kind   = KIND_STATUS;
      emit_data.action = ACT_SPLIT;
      emit_data.pt     = '0;
      emit_data.face   = '0;
      emit_data.bl     = o_ff;
      emit_data.br     = rbase_ff;
      emit_data.last   = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               o_in    = q_item.o;
               lin_in  = q_item.lft;
               rin_in  = q_item.rgt;
               face_in = q_item.face;
               if (!q_item.func) begin
                  lwe      = 1'b1;
                  rwe      = 1'b1;
                  lwd      = q_item.o;
                  rwd      = q_item.o;
                  state_in = S_START2;
               end else if (lcnt_ff < CNT_W'(2) || rcnt_ff < CNT_W'(2)) begin
                  action_in = ACT_ERROR;
                  state_in  = S_STATUS;
               end else begin
                  state_in = S_ORL0;
               end
            end
         end
         S_START2: begin
            lwe       = 1'b1;
            rwe       = 1'b1;
            lwa       = IDX_W'(1);
            rwa       = IDX_W'(1);
            lwd       = lin_ff;
            rwd       = rin_ff;
            lcnt_in   = CNT_W'(2);
            rcnt_in   = CNT_W'(2);
            lbase_in  = lin_ff;
            rbase_in  = rin_ff;
            action_in = ACT_STARTED;
            state_in  = S_STATUS;
         end
         S_ORL0: begin
            ori_req.start = 1'b1;
            state_in      = S_ORL;
         end
         S_ORL: begin
            if (ori_rsp.done) begin
               lo_in    = ori_rsp.res;
               state_in = S_ORR0;
            end
         end
         S_ORR0: begin
            ori_req.start = 1'b1;
            ori_req.a     = r0_ff;
            ori_req.b     = r1_ff;
            state_in      = S_ORR;
         end
         S_ORR: begin
            if (ori_rsp.done) begin
               ro_in    = ori_rsp.res;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (lo_ff == ORI_RIGHT && ro_ff == ORI_LEFT) begin
               state_in = S_SNB;
            end else begin
               side_in = (lo_ff != ORI_RIGHT);
               prev_in = (lo_ff != ORI_RIGHT) ? l1_ff : r1_ff;
               if ((lo_ff != ORI_RIGHT) ? (lo_ff == ORI_RIGHT) : (ro_ff == ORI_LEFT)) begin
                  hit_in   = 1'b1;
                  i_in     = CNT_W'(1);
                  state_in = S_APPLY;
               end else begin
                  hit_in = 1'b0;
                  i_in   = CNT_W'(2);
                  if (((lo_ff != ORI_RIGHT) ? lcnt_ff : rcnt_ff) == CNT_W'(2)) begin
                     state_in = S_APPLY;
                  end else begin
                     state_in = S_WRD;
                  end
               end
            end
         end
         S_WRD: begin
            rd_en    = 1'b1;
            state_in = S_WOR;
         end
         S_WOR: begin
            ori_req.start = 1'b1;
            ori_req.a     = prev_ff;
            ori_req.b     = rd_pt;
            prev_in       = rd_pt;
            state_in      = S_WWAIT;
         end
         S_WWAIT: begin
            if (ori_rsp.done) begin
               if (ori_rsp.res == target) begin
                  hit_in   = 1'b1;
                  state_in = S_APPLY;
               end else if ((i_ff + CNT_W'(1)) == (side_ff ? lcnt_ff : rcnt_ff)) begin
                  state_in = S_APPLY;
               end else begin
                  i_in     = i_ff + CNT_W'(1);
                  state_in = S_WRD;
               end
            end
         end
         S_APPLY: begin
            state_in = S_STATUS;
            if (hit_ff) begin
               if (side_ff) begin
                  lwe       = 1'b1;
                  lwa       = i_ff[IDX_W-1:0];
                  lcnt_in   = i_ff + CNT_W'(1);
                  lbase_in  = o_ff;
                  action_in = ACT_SHR_LEFT;
               end else begin
                  rwe       = 1'b1;
                  rwa       = i_ff[IDX_W-1:0];
                  rcnt_in   = i_ff + CNT_W'(1);
                  rbase_in  = o_ff;
                  action_in = ACT_SHR_RIGHT;
               end
            end else if ((side_ff ? lcnt_ff : rcnt_ff) >= CNT_W'(CHAIN_DEPTH)) begin
               action_in = ACT_ERROR;
            end else if (side_ff) begin
               lwe       = 1'b1;
               lwa       = lcnt_ff[IDX_W-1:0];
               lcnt_in   = lcnt_ff + CNT_W'(1);
               lbase_in  = o_ff;
               action_in = ACT_EXT_LEFT;
            end else begin
               rwe       = 1'b1;
               rwa       = rcnt_ff[IDX_W-1:0];
               rcnt_in   = rcnt_ff + CNT_W'(1);
               rbase_in  = o_ff;
               action_in = ACT_EXT_RIGHT;
            end
         end
         S_STATUS: begin
            emit_data.kind   = KIND_STATUS;
            emit_data.action = action_ff;
            emit_data.bl     = (lcnt_ff == '0) ? '0 : lbase_ff;
            emit_data.br     = (rcnt_ff == '0) ? '0 : rbase_ff;
            emit_data.last   = 1'b1;
            if (can_emit) begin
               emit     = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_SNB: begin
            emit_data.kind = KIND_NEIGH;
            emit_data.pt   = o_ff;
            emit_data.face = face_ff;
            side_in        = 1'b1;
            i_in           = '0;
            if (can_emit) begin
               emit     = 1'b1;
               state_in = S_SRD;
            end
         end
         S_SRD: begin
            rd_en    = 1'b1;
            state_in = S_SEM;
         end
         S_SEM: begin
            emit_data.kind = KIND_LEFT;
            emit_data.pt   = lrd_ff;
            if (can_emit) begin
               emit = 1'b1;
               i_in = i_ff + CNT_W'(1);
               if ((i_ff + CNT_W'(1)) == lcnt_ff) begin
                  state_in = S_SAPEX;
               end else begin
                  state_in = S_SRD;
               end
            end
         end
         S_SAPEX: begin
            emit_data.kind = KIND_RIGHT;
            emit_data.pt   = l0_ff;
            if (can_emit) begin
               emit     = 1'b1;
               state_in = S_SO;
            end
         end
         S_SO: begin
            emit_data.kind = KIND_RIGHT;
            emit_data.pt   = o_ff;
            emit_data.last = 1'b1;
            if (can_emit) begin
               emit     = 1'b1;
               state_in = S_SW0;
            end
         end
         S_SW0: begin
            lwe      = 1'b1;
            lwd      = r0_ff;
            state_in = S_SW1;
         end
         S_SW1: begin
            lwe      = 1'b1;
            lwa      = IDX_W'(1);
            lcnt_in  = CNT_W'(2);
            lbase_in = o_ff;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // mirror of the first two entries of each chain
      if (lwe && lwa == IDX_W'(0)) l0_in = lwd;
      if (lwe && lwa == IDX_W'(1)) l1_in = lwd;
      if (rwe && rwa == IDX_W'(0)) r0_in = rwd;
      if (rwe && rwa == IDX_W'(1)) r1_in = rwd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         lcnt_ff      <= '0;
         rcnt_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         lcnt_ff  <= lcnt_in;
         rcnt_ff  <= rcnt_in;
         if (emit) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      i_ff      <= i_in;
      l0_ff     <= l0_in;
      l1_ff     <= l1_in;
      r0_ff     <= r0_in;
      r1_ff     <= r1_in;
      lbase_ff  <= lbase_in;
      rbase_ff  <= rbase_in;
      o_ff      <= o_in;
      lin_ff    <= lin_in;
      rin_ff    <= rin_in;
      prev_ff   <= prev_in;
      face_ff   <= face_in;
      lo_ff     <= lo_in;
      ro_ff     <= ro_in;
      side_ff   <= side_in;
      hit_ff    <= hit_in;
      action_ff <= action_in;
      if (emit) begin
         out_ff <= emit_data;
      end
   end

   // chain memories: one write and one registered read each
   always_ff @(posedge clock) begin
      if (lwe) begin
         left_mem[lwa] <= lwd;
      end
      if (rwe) begin
         right_mem[rwa] <= rwd;
      end
      if (rd_en) begin
         lrd_ff <= left_mem[rd_addr];
         rrd_ff <= right_mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

### hdl/funnel_chain_update.sv
// ---------------------------------------------------------------------------
// funnel_chain_update: funnel kept as a left and a right point chain
// Start, split, extend and shrink of the funnel on each opposite vertex.
// ---------------------------------------------------------------------------
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+-----------------------------------
//  req_    | in  | req_tvalid/req_tready | tdata: point items, tuser: func
//  rsp_    | out | rsp_tvalid/rsp_tready | tdata: result, tuser: kind, tlast
//
// Start transaction: both chains are written, then the status result is emitted.
// Opposite vertex: two orientation tests, then a memory read and an orientation
// test through the 3 stage orientation pipeline per further chain segment walked;
// a split emits CHAIN_DEPTH+3 results at most, each stored left point needing a
// registered memory read before its result (one memory read port).
// Reset clears the queue, the sequencer, the chain counts and the result valid
// flag; chain memory and result data contents are left as they are.
// A 2 deep queue lets req_ take up to two items while the sequencer or rsp_ stalls.
// ---------------------------------------------------------------------------
`default_nettype none

module funnel_chain_update import fcu_pkg::*; #(
   parameter int CHAIN_DEPTH = DEF_CHAIN_DEPTH,
   parameter int COORD_BITS  = DEF_COORD_BITS
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // px, py, left_x, left_y, right_x, right_y, face_id
   input  wire logic [215:0] req_tdata,
   // func
   input  wire logic [0:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // action, out_x, out_y, out_face, base_left_x, base_left_y,
   // base_right_x, base_right_y, zero fill
   output logic [223:0]      rsp_tdata,
   // kind
   output logic [1:0]        rsp_tuser,
   output logic              rsp_tlast
);

   item_type in_item, q_item;
   logic     q_valid, q_pop;
   rsp_type  out_data;

   // unpack the request transaction
   assign in_item.func  = req_tuser[0];
   assign in_item.o.x   = req_tdata[31:0];
   assign in_item.o.y   = req_tdata[63:32];
   assign in_item.lft.x = req_tdata[95:64];
   assign in_item.lft.y = req_tdata[127:96];
   assign in_item.rgt.x = req_tdata[159:128];
   assign in_item.rgt.y = req_tdata[191:160];
   assign in_item.face  = req_tdata[215:192];

   fcu_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_item  (in_item),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_pop    (q_pop)
   );

   fcu_back #(
      .CHAIN_DEPTH (CHAIN_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .out_valid (rsp_tvalid),
      .out_data  (out_data),
      .out_ready (rsp_tready)
   );

   // pack the result transaction, lowest field first
   assign rsp_tdata = {5'd0, out_data.br.y, out_data.br.x, out_data.bl.y,
                       out_data.bl.x, out_data.face, out_data.pt.y,
                       out_data.pt.x, out_data.action};
   assign rsp_tuser = out_data.kind;
   assign rsp_tlast = out_data.last;

endmodule

`default_nettype wire

### sim/tb_funnel_chain_update.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_funnel_chain_update: self-checking bench for the funnel chain update
// Drives start and opposite-vertex transactions, predicts every result with
// an independent funnel model and checks the result stream field by field.
// ---------------------------------------------------------------------------

module tb_funnel_chain_update;
   import fcu_pkg::*;

   localparam int DEPTH      = DEF_CHAIN_DEPTH;
   localparam int IDLE_LIMIT = 5000;   // cycles with no transaction at all
   localparam int TARGET     = 320;

   // funnel model plus the queue of results still owed by the block
   class funnel_scoreboard;
      point_type lch[DEPTH];
      point_type rch[DEPTH];
      int        lcnt, rcnt;
      rsp_type   owed[$];
      int        errors, checked;
      int        act_hits[8];

      function point_type chain_end(int which);
         point_type z;
         z = '0;
         if (which == 0 && lcnt > 0) z = lch[lcnt-1];
         if (which == 1 && rcnt > 0) z = rch[rcnt-1];
         return z;
      endfunction

      // +1 right of a->b, -1 left, 0 collinear; exact in 68 bits
      function int side_of(point_type o, point_type a, point_type b);
         logic signed [67:0] dx1, dy1, dx2, dy2, cr;
         dx1 = b.x; dx1 = dx1 - a.x;
         dy1 = b.y; dy1 = dy1 - a.y;
         dx2 = o.x; dx2 = dx2 - a.x;
         dy2 = o.y; dy2 = dy2 - a.y;
         cr  = dx1 * dy2 - dy1 * dx2;
         if (cr < 0) return 1;
         if (cr > 0) return -1;
         return 0;
      endfunction

      function void owe(logic [1:0] kind, logic [2:0] act, point_type pt,
                        logic [FACE_W-1:0] face, point_type bl, point_type br);
         rsp_type r;
         r.kind = kind; r.action = act; r.pt = pt; r.face = face;
         r.bl = bl; r.br = br; r.last = 1'b0;
         owed = {owed, r};
         act_hits[act]++;
      endfunction

      function void note(item_type it);
         logic [2:0] act;
         int lo, ro, cut, side;
         point_type br, z;
         z = '0;
         if (it.func == 1'b0) begin
            lch[0] = it.o; lch[1] = it.lft;
            rch[0] = it.o; rch[1] = it.rgt;
            lcnt = 2; rcnt = 2;
            act = ACT_STARTED;
         end else if (lcnt < 2 || rcnt < 2) begin
            act = ACT_ERROR;   // opposite vertex with no funnel loaded
         end else begin
            lo = side_of(it.o, lch[0], lch[1]);
            ro = side_of(it.o, rch[0], rch[1]);
            if (lo == 1 && ro == -1) begin
               // split: neighbour, old left chain, then old apex and o
               br = chain_end(1);
               owe(KIND_NEIGH, ACT_SPLIT, it.o, it.face, it.o, br);
               for (int i = 0; i < lcnt; i++)
                  owe(KIND_LEFT, ACT_SPLIT, lch[i], '0, it.o, br);
               owe(KIND_RIGHT, ACT_SPLIT, lch[0], '0, it.o, br);
               owe(KIND_RIGHT, ACT_SPLIT, it.o, '0, it.o, br);
               owed[$].last = 1'b1;
               lch[0] = rch[0]; lch[1] = it.o; lcnt = 2;
               return;
            end
            side = (lo != 1) ? 1 : -1;   // 1: left chain, -1: right chain
            cut  = -1;
            if (side == 1) begin
               for (int i = 1; i < lcnt && cut < 0; i++)
                  if (side_of(it.o, lch[i-1], lch[i]) == 1) cut = i - 1;
               if (cut >= 0) begin
                  lch[cut+1] = it.o; lcnt = cut + 2; act = ACT_SHR_LEFT;
               end else if (lcnt >= DEPTH) act = ACT_ERROR;
               else begin
                  lch[lcnt] = it.o; lcnt++; act = ACT_EXT_LEFT;
               end
            end else begin
               for (int i = 1; i < rcnt && cut < 0; i++)
                  if (side_of(it.o, rch[i-1], rch[i]) == -1) cut = i - 1;
               if (cut >= 0) begin
                  rch[cut+1] = it.o; rcnt = cut + 2; act = ACT_SHR_RIGHT;
               end else if (rcnt >= DEPTH) act = ACT_ERROR;
               else begin
                  rch[rcnt] = it.o; rcnt++; act = ACT_EXT_RIGHT;
               end
            end
         end
         owe(KIND_STATUS, act, z, '0, chain_end(0), chain_end(1));
         owed[$].last = 1'b1;
      endfunction

      function void check(rsp_type got);
         rsp_type w;
         checked++;
         if (owed.size() == 0) begin
            $display("%0t: unexpected result kind=%0d action=%0d", $time,
                     got.kind, got.action);
            errors++;
            return;
         end
         w = owed.pop_front();
         if (got.kind != w.kind) begin
            $display("%0t: kind exp %0d got %0d", $time, w.kind, got.kind); errors++;
         end
         if (got.action != w.action) begin
            $display("%0t: action exp %0d got %0d", $time, w.action, got.action);
            errors++;
         end
         if (got.pt != w.pt) begin
            $display("%0t: point exp (%0d,%0d) got (%0d,%0d)", $time,
                     w.pt.x, w.pt.y, got.pt.x, got.pt.y); errors++;
         end
         if (got.face != w.face) begin
            $display("%0t: face exp %h got %h", $time, w.face, got.face); errors++;
         end
         if (got.bl != w.bl) begin
            $display("%0t: left base exp (%0d,%0d) got (%0d,%0d)", $time,
                     w.bl.x, w.bl.y, got.bl.x, got.bl.y); errors++;
         end
         if (got.br != w.br) begin
            $display("%0t: right base exp (%0d,%0d) got (%0d,%0d)", $time,
                     w.br.x, w.br.y, got.br.x, got.br.y); errors++;
         end
         if (got.last != w.last) begin
            $display("%0t: tlast exp %0d got %0d", $time, w.last, got.last); errors++;
         end
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [215:0] req_tdata;   // px, py, left_x, left_y, right_x, right_y, face_id
   logic [0:0]   req_tuser;   // func
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [223:0] rsp_tdata;   // action, out_x, out_y, out_face, base_left_x/y,
                              // base_right_x/y, zero fill
   logic [1:0]   rsp_tuser;   // kind
   logic         rsp_tlast;

   funnel_scoreboard sb;
   int  sent;
   int  idle_cycles;
   bit  quiet;      // no idling on either side
   bit  hold_req;   // ask the receiver for a long hold-off

   funnel_chain_update uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   always begin
      clock = 1'b0; #6;
      clock = 1'b1; #6;
   end

   // receiver: random back-pressure, or a long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_req = 1'b0;
            rsp_tready <= 1'b1;
         end else
            rsp_tready <= quiet || ($urandom_range(0, 99) >= 8);
      end
   end

   // result monitor
   always @(posedge clock) begin
      rsp_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind   = rsp_tuser;
         got.action = rsp_tdata[2:0];
         got.pt.x   = rsp_tdata[34:3];
         got.pt.y   = rsp_tdata[66:35];
         got.face   = rsp_tdata[90:67];
         got.bl.x   = rsp_tdata[122:91];
         got.bl.y   = rsp_tdata[154:123];
         got.br.x   = rsp_tdata[186:155];
         got.br.y   = rsp_tdata[218:187];
         got.last   = rsp_tlast;
         sb.check(got);
      end
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   function automatic point_type pt_of(int x, int y);
      point_type p;
      p.x = x; p.y = y;
      return p;
   endfunction

   function automatic item_type mk(logic f, point_type o, point_type l,
                                   point_type r, logic [FACE_W-1:0] face);
      item_type it;
      it.func = f; it.o = o; it.lft = l; it.rgt = r; it.face = face;
      return it;
   endfunction

   function automatic point_type small_pt(int span);
      return pt_of($urandom_range(0, 2*span) - span, $urandom_range(0, 2*span) - span);
   endfunction

   // one transaction: optional idle gap, then hold valid until accepted
   task automatic send_item(item_type it);
      if (!quiet && $urandom_range(0, 99) < 8) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {it.face, it.rgt.y, it.rgt.x, it.lft.y, it.lft.x, it.o.y, it.o.x};
      req_tuser  <= it.func;
      do @(posedge clock); while (!req_tready);
      sb.note(it);
      sent++;
   endtask

   task automatic vertex(int x, int y);
      send_item(mk(1'b1, pt_of(x, y), '0, '0, FACE_W'($urandom_range(0, 24'hFFFFFF))));
   endtask

   // collinear left chain grown to full depth, two extends too many, then a
   // split that emits the longest result burst
   task automatic column_run();
      send_item(mk(1'b0, pt_of(0, 0), pt_of(0, 1), pt_of(10, 1), '0));
      for (int k = 2; k <= DEPTH; k++) vertex(0, k);
      vertex(0, DEPTH + 5);
      vertex(5, 100);
   endtask

   // start with random geometry, then a run of nearby opposite vertices
   task automatic random_funnel(int len);
      send_item(mk(1'b0, small_pt(200), small_pt(300), small_pt(300),
                   FACE_W'($urandom_range(0, 24'hFFFFFF))));
      for (int k = 0; k < len; k++) begin
         point_type p;
         p = small_pt(400);
         vertex(p.x, p.y);
      end
   endtask

   task automatic noise_item();
      item_type it;
      it = $bits(item_type)'({$urandom, $urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom});
      it.func = 1'($urandom_range(0, 1));
      send_item(it);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.owed.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   localparam int MINV = 32'h8000_0000;
   localparam int MAXV = 32'h7FFF_FFFF;

   initial begin
      bit held, paused;
      sb = new();
      sent = 0; quiet = 1'b0; hold_req = 1'b0; held = 0; paused = 0;
      reset = 1'b1; req_tvalid = 1'b0; req_tdata = '0; req_tuser = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: missing start, basic moves on each side, extreme coordinates
      vertex(3, 4);
      send_item(mk(1'b0, pt_of(0, 0), pt_of(-100, 100), pt_of(100, 100), 24'h000001));
      send_item(mk(1'b1, pt_of(0, 50), '0, '0, 24'hFFFFFF));   // inside: split
      vertex(-200, 300);
      vertex(-1, 400);
      vertex(-500, 100);
      vertex(300, 100);
      vertex(600, 900);
      vertex(250, 120);
      vertex(0, 0);                                            // collinear apex
      send_item(mk(1'b0, pt_of(MINV, MINV), pt_of(MINV, MAXV), pt_of(MAXV, MAXV),
                   24'h000000));
      send_item(mk(1'b1, pt_of(MAXV, MINV), '0, '0, 24'hFFFFFF));
      vertex(MINV + 1, MAXV);
      vertex(0, 0);
      vertex(MAXV, MAXV);
      send_item(mk(1'b0, pt_of(MAXV, MAXV), pt_of(MINV, MINV), pt_of(MAXV, MINV),
                   24'hABCDEF));
      vertex(MINV, MAXV);
      vertex(MAXV - 1, MINV);
      drain();

      column_run();

      // random: mostly well-formed funnels, some long chains, some noise
      while (sent < TARGET) begin
         int r;
         r = $urandom_range(0, 99);
         quiet = (sent > 220 && sent < 270);
         if (!held && sent > 100) begin
            hold_req = 1'b1;   // block fills up while the sender keeps going
            held = 1;
         end
         if (!paused && sent > 190) begin
            drain();
            paused = 1;
         end
         if (r < 8) noise_item();
         else if (r < 11) column_run();
         else random_funnel($urandom_range(4, 16));
      end
      quiet = 1'b0;

      drain();
      $display("Covered %0d transactions in, %0d results checked", sent, sb.checked);
      $display("Actions: split %0d ext/shr L %0d/%0d ext/shr R %0d/%0d start %0d err %0d",
               sb.act_hits[ACT_SPLIT], sb.act_hits[ACT_EXT_LEFT], sb.act_hits[ACT_SHR_LEFT],
               sb.act_hits[ACT_EXT_RIGHT], sb.act_hits[ACT_SHR_RIGHT],
               sb.act_hits[ACT_STARTED], sb.act_hits[ACT_ERROR]);
      if (sb.errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
